// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared types, request codes and constants of the task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_TASKS_DEFAULT = 8;
   localparam logic [7:0] NO_PRIORITY = 8'd255;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_YIELD   = 3'd1,
      REQ_CREATE  = 3'd2,
      REQ_REMOVE  = 3'd3,
      REQ_BLOCK   = 3'd4,
      REQ_UNBLOCK = 3'd5,
      REQ_SWITCH  = 3'd6,
      REQ_NONE    = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_RUNNING = 2'd1,
      ST_BLOCKED = 2'd2
   } task_st_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_PREP,
      CTL_SHIFT,
      CTL_SCAN,
      CTL_FINISH,
      CTL_OUT
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  priority_req;
      logic [2:0]  slot;
      logic [31:0] wake_tick;
      logic [31:0] context_ptr;
   } req_word_type;

   typedef struct packed {
      logic        pend_switch;
      logic [31:0] next_stack_pointer;
      logic [3:0]  running_task;
      logic [3:0]  selected_task;
      logic [1:0]  status;
      logic [3:0]  task_count;
      logic [31:0] tick_count;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture request and apply its direct table update
      logic shift;    // move one entry down during compaction
      logic setup;    // start a scheduling pass
      logic scan;     // visit one slot in the scheduling pass
      logic finish;   // close the pass, settle chosen slot
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic shift_done;
      logic scan_done;
      logic need_pass;
      logic need_shift;
   } sts_type;

endpackage

// ===== rtl/core/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one request: load, any table compaction and scheduling pass, result.
// ----------------------------------------------------------------------------
module pts_ctrl
   import pts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTL_PREP;
            end
         end
         CTL_PREP: begin
            priority if (sts.need_shift) begin
               state_in = CTL_SHIFT;
            end else if (sts.need_pass) begin
               cmd.setup = 1'b1;
               state_in  = CTL_SCAN;
            end else begin
               state_in = CTL_OUT;
            end
         end
         CTL_SHIFT: begin
            if (sts.shift_done) begin
               cmd.setup = 1'b1;
               state_in  = CTL_SCAN;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         CTL_SCAN: begin
            if (sts.scan_done) begin
               state_in = CTL_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         CTL_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = CTL_OUT;
         end
         CTL_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/pts_dpath.sv =====
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table, counters, compaction and one-slot-per-cycle selection logic.
// ----------------------------------------------------------------------------
module pts_dpath
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  logic         csr_write,
   input  logic [31:0]  csr_data,
   input  cmd_type      cmd,
   output sts_type      sts,
   output rsp_word_type rsp_word
);

   localparam int SW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] IDLE = CW'(MAX_TASKS);

   logic [1:0]    state_ff [MAX_TASKS];
   logic [7:0]    prio_ff  [MAX_TASKS];
   logic [31:0]   wake_ff  [MAX_TASKS];
   logic [31:0]   ctx_ff   [MAX_TASKS + 1];
   logic [CW-1:0] count_ff, cur_ff, chosen_ff;
   logic          start_ff;
   logic [31:0]   tick_ff;

   logic          pend_ff;
   logic [31:0]   nsp_ff;
   logic [1:0]    status_ff;
   logic          pass_ff, shift_ff;
   logic [CW-1:0] pos_ff;      // shift position or scan index
   logic [CW-1:0] j_ff;        // rotation pointer
   logic [CW-1:0] ecur_ff;     // effective current during the pass
   logic [7:0]    best_ff;
   logic [CW-1:0] pick_ff;
   logic          found_ff;

   logic [CW-1:0] cur_eff, chs_eff, slot_after;
   logic          slot_ok;
   logic [SW-1:0] j_idx;
   logic [1:0]    st_j;

   assign slot_ok = (32'(req_word.slot) < 32'(count_ff));
   assign cur_eff = (cur_ff < count_ff) ? cur_ff : IDLE;
   assign chs_eff = (chosen_ff < count_ff) ? chosen_ff : IDLE;
   assign j_idx   = j_ff[SW-1:0];

   // Wake-up check folded into the visited slot's state.
   always_comb begin
      st_j = state_ff[j_idx];
      if (state_ff[j_idx] == ST_BLOCKED && wake_ff[j_idx] != 32'd0
          && tick_ff >= wake_ff[j_idx]) begin
         st_j = ST_READY;
      end
   end

   assign slot_after = (j_ff + 1'b1 >= count_ff) ? '0 : j_ff + 1'b1;

   assign sts.need_pass  = pass_ff;
   assign sts.need_shift = shift_ff;
   assign sts.shift_done = (pos_ff >= count_ff);
   assign sts.scan_done  = (pos_ff >= count_ff);

   function automatic logic [CW-1:0] follow(input logic [CW-1:0] s,
                                            input logic [CW-1:0] gone);
      logic [CW-1:0] r;
      r = s;
      if (s < IDLE) begin
         if (s == gone) r = IDLE;
         else if (s > gone) r = s - 1'b1;
      end
      return r;
   endfunction

   // Table and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            state_ff[i] <= ST_READY;
            wake_ff[i]  <= '0;
         end
         count_ff  <= '0;
         cur_ff    <= '0;
         chosen_ff <= '0;
         start_ff  <= 1'b1;
         tick_ff   <= '0;
         pass_ff   <= 1'b0;
         shift_ff  <= 1'b0;
         ctx_ff[MAX_TASKS] <= '0;
      end else begin
         if (csr_write) begin
            ctx_ff[MAX_TASKS] <= csr_data;
         end
         if (cmd.load) begin
            pend_ff   <= 1'b0;
            nsp_ff    <= '0;
            status_ff <= STATUS_OK;
            pass_ff   <= 1'b0;
            shift_ff  <= 1'b0;
            unique case (req_code_type'(req_word.req_type))
               REQ_TICK: begin
                  tick_ff <= tick_ff + 32'd1;
                  pass_ff <= 1'b1;
                  pend_ff <= 1'b1;
               end
               REQ_YIELD: pass_ff <= 1'b1;
               REQ_CREATE: begin
                  if (count_ff < IDLE) begin
                     state_ff[count_ff[SW-1:0]] <= ST_READY;
                     prio_ff[count_ff[SW-1:0]]  <= req_word.priority_req;
                     wake_ff[count_ff[SW-1:0]]  <= '0;
                     ctx_ff[count_ff]           <= req_word.context_ptr;
                     count_ff                   <= count_ff + 1'b1;
                  end else begin
                     status_ff <= STATUS_FULL;
                  end
               end
               REQ_REMOVE: begin
                  pass_ff <= 1'b1;
                  if (slot_ok) begin
                     shift_ff  <= 1'b1;
                     cur_ff    <= follow(cur_ff, CW'(req_word.slot));
                     chosen_ff <= follow(chosen_ff, CW'(req_word.slot));
                  end else begin
                     status_ff <= STATUS_ABSENT;
                  end
               end
               REQ_BLOCK: begin
                  pass_ff <= 1'b1;
                  if (cur_ff < count_ff) begin
                     state_ff[cur_ff[SW-1:0]] <= ST_BLOCKED;
                     wake_ff[cur_ff[SW-1:0]]  <= req_word.wake_tick;
                  end
               end
               REQ_UNBLOCK: begin
                  if (slot_ok) state_ff[SW'(req_word.slot)] <= ST_READY;
                  else status_ff <= STATUS_ABSENT;
               end
               REQ_SWITCH: begin
                  if (start_ff) begin
                     start_ff <= 1'b0;
                     if (count_ff != '0) begin
                        cur_ff      <= '0;
                        chosen_ff   <= '0;
                        state_ff[0] <= ST_RUNNING;
                        nsp_ff      <= ctx_ff[0];
                     end else begin
                        cur_ff    <= IDLE;
                        chosen_ff <= IDLE;
                        nsp_ff    <= ctx_ff[MAX_TASKS];
                     end
                  end else if (chs_eff != cur_eff) begin
                     if (cur_eff < IDLE && state_ff[cur_eff[SW-1:0]] == ST_RUNNING)
                        state_ff[cur_eff[SW-1:0]] <= ST_READY;
                     ctx_ff[cur_eff] <= req_word.context_ptr;
                     cur_ff          <= chs_eff;
                     if (chs_eff < IDLE) state_ff[chs_eff[SW-1:0]] <= ST_RUNNING;
                     nsp_ff <= ctx_ff[chs_eff];
                  end else begin
                     ctx_ff[cur_eff] <= req_word.context_ptr;
                     cur_ff          <= cur_eff;
                     nsp_ff          <= req_word.context_ptr;
                  end
               end
               default: ;
            endcase
            pos_ff <= CW'(req_word.slot);
         end

         // Compaction: one entry moves down per cycle, count drops at end.
         if (cmd.shift) begin
            if (pos_ff + 1'b1 < count_ff) begin
               state_ff[pos_ff[SW-1:0]] <= state_ff[SW'(pos_ff + 1'b1)];
               prio_ff[pos_ff[SW-1:0]]  <= prio_ff[SW'(pos_ff + 1'b1)];
               wake_ff[pos_ff[SW-1:0]]  <= wake_ff[SW'(pos_ff + 1'b1)];
               ctx_ff[pos_ff]           <= ctx_ff[pos_ff + 1'b1];
            end else begin
               count_ff <= count_ff - 1'b1;
               shift_ff <= 1'b0;
            end
            pos_ff <= pos_ff + 1'b1;
         end

         // Pass setup: latch effective current and the rotation start.
         if (cmd.setup) begin
            pos_ff   <= '0;
            ecur_ff  <= cur_eff;
            j_ff     <= (cur_eff < IDLE && cur_eff + 1'b1 < count_ff)
                        ? cur_eff + 1'b1 : '0;
            best_ff  <= NO_PRIORITY;
            pick_ff  <= IDLE;
            found_ff <= 1'b0;
         end

         // Scan step: visit slot j; after the first switch, wake it if due and compare its priority.
         if (cmd.scan) begin
            if (!start_ff) begin
               if (st_j != state_ff[j_idx]) begin
                  state_ff[j_idx] <= st_j;
                  wake_ff[j_idx]  <= '0;
               end
               if (st_j == ST_READY && prio_ff[j_idx] < best_ff) begin
                  best_ff  <= prio_ff[j_idx];
                  pick_ff  <= j_ff;
                  found_ff <= 1'b1;
               end
            end
            j_ff   <= slot_after;
            pos_ff <= pos_ff + 1'b1;
         end

         // Close the pass. A tick already pends; others pend when the
         // current task is still blocked.
         if (cmd.finish) begin
            pass_ff <= 1'b0;
            if (start_ff) begin
               cur_ff    <= (count_ff != '0) ? '0 : IDLE;
               chosen_ff <= (count_ff != '0) ? '0 : IDLE;
            end else begin
               if (found_ff) chosen_ff <= pick_ff;
               else if (ecur_ff < IDLE && state_ff[ecur_ff[SW-1:0]] == ST_RUNNING)
                  chosen_ff <= ecur_ff;
               else chosen_ff <= IDLE;
               if (ecur_ff < IDLE && state_ff[ecur_ff[SW-1:0]] == ST_BLOCKED)
                  pend_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_word.pend_switch        = pend_ff;
   assign rsp_word.next_stack_pointer = nsp_ff;
   assign rsp_word.running_task       = 4'(cur_ff);
   assign rsp_word.selected_task      = 4'(chosen_ff);
   assign rsp_word.status             = status_ff;
   assign rsp_word.task_count         = 4'(count_ff);
   assign rsp_word.tick_count         = tick_ff;

endmodule

// ===== rtl/core/priority_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Priority task scheduler unit
//
// Channel   Direction  Handshake        Word
// req_      in         valid / stall    req_word_type
// rsp_      out        valid / stall    rsp_word_type
// csr_      in         valid / ready    idle stack pointer, 32 bits
//
// One request at a time. Each request passes through load, prepare and
// output; a scheduling pass adds a scan of every table slot and a finish
// step, and a remove of a held slot first compacts the table. The pass walks
// the slots one per cycle through a single compare unit. Reset is
// synchronous and active high. A stalled response holds the unit until it
// is taken.
// ----------------------------------------------------------------------------
module priority_task_scheduler_unit
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   pts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   pts_dpath #(.MAX_TASKS(MAX_TASKS)) u_dpath (
      .clock, .reset, .req_word,
      .csr_write (csr_valid && csr_ready),
      .csr_data, .cmd, .sts, .rsp_word
   );

   // A request is never taken while a response is offered.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("accept during response");

   // The table never holds more than its capacity.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.task_count <= 4'(MAX_TASKS))
      else $error("task count overflow");

endmodule

// ===== tb/tb_priority_task_scheduler_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority task scheduler unit testbench
// A short table of directed requests and then constrained-free random
// requests go to the unit; a model of the table, the wake-ups, the rotation
// and the context switches predicts each untyped response, and each field is checked.
// ----------------------------------------------------------------------------
module tb_priority_task_scheduler_unit;
   import pts_pkg::*;

   localparam int unsigned IDLE_SLOT = 8;
   localparam int unsigned TASK_SLOTS = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   // Idle and stall modes of the random phases.
   localparam int MODE_FREE = 0;
   localparam int MODE_SEND_IDLE = 1;
   localparam int MODE_RECV_STALL = 2;
   localparam int MODE_BOTH = 3;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   // Scheduler state as predicted.
   task_st_type  sched_state [TASK_SLOTS];
   logic [7:0]   sched_prio [TASK_SLOTS];
   logic [31:0]  sched_wake [TASK_SLOTS];
   logic [31:0]  sched_context [TASK_SLOTS + 1];
   int unsigned  tasks_held;
   int unsigned  run_slot;
   int unsigned  chosen_task;
   bit           booting;
   logic [31:0]  ticks;

   rsp_word_type pending_rsps [$];
   stim_row_type directed_rows [25];
   int           error_count;
   int           mode;
   int           cycle_count;
   int           hold_until;
   int           quiet_cycles;
   int           words_sent;
   int           words_checked;
   int           switches_seen;

   priority_task_scheduler_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // A slot that holds no task stands for the idle task.
   function automatic int unsigned live_slot(int unsigned s);
      return (s < tasks_held && s < TASK_SLOTS) ? s : IDLE_SLOT;
   endfunction

   // Scheduling pass: wakes due tasks, picks the best ready one in rotation
   // order. Returns one when the current task is still blocked.
   function automatic bit sched_pass();
      int unsigned c;
      int unsigned j;
      int unsigned best;
      int unsigned pick;
      bit          found;
      if (booting) begin
         run_slot = (tasks_held > 0) ? 0 : IDLE_SLOT;
         chosen_task = run_slot;
         return 1'b0;
      end
      c = live_slot(run_slot);
      j = (c < IDLE_SLOT && c + 1 < tasks_held) ? c + 1 : 0;
      best = 255;
      pick = IDLE_SLOT;
      found = 1'b0;
      for (int unsigned i = 0; i < tasks_held; i++) begin
         if (sched_state[j] == ST_BLOCKED && sched_wake[j] != 0 && ticks >= sched_wake[j]) begin
            sched_state[j] = ST_READY;
            sched_wake[j] = 32'd0;
         end
         if (sched_state[j] == ST_READY && sched_prio[j] < best) begin
            best = sched_prio[j];
            pick = j;
            found = 1'b1;
         end
         j++;
         if (j >= tasks_held) j = 0;
      end
      if (found) chosen_task = pick;
      else if (c < IDLE_SLOT && sched_state[c] == ST_RUNNING) chosen_task = c;
      else chosen_task = IDLE_SLOT;
      return c < IDLE_SLOT && sched_state[c] == ST_BLOCKED;
   endfunction

   function automatic int unsigned after_remove(int unsigned s, int unsigned gone);
      if (s >= IDLE_SLOT) return s;
      if (s == gone) return IDLE_SLOT;
      return (s > gone) ? s - 1 : s;
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic rsp_word_type schedule_request(req_word_type w);
      rsp_word_type r;
      int unsigned  s;
      int unsigned  c;
      int unsigned  n;
      r = '0;
      s = w.slot;
      case (req_code_type'(w.req_type))
         REQ_TICK: begin
            ticks = ticks + 32'd1;
            void'(sched_pass());
            r.pend_switch = 1'b1;
         end
         REQ_YIELD: r.pend_switch = sched_pass();
         REQ_CREATE: begin
            if (tasks_held < TASK_SLOTS) begin
               sched_state[tasks_held] = ST_READY;
               sched_prio[tasks_held] = w.priority_req;
               sched_wake[tasks_held] = 32'd0;
               sched_context[tasks_held] = w.context_ptr;
               tasks_held++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         REQ_REMOVE: begin
            if (live_slot(s) != IDLE_SLOT) begin
               for (int unsigned i = s; i + 1 < tasks_held; i++) begin
                  sched_state[i] = sched_state[i + 1];
                  sched_prio[i] = sched_prio[i + 1];
                  sched_wake[i] = sched_wake[i + 1];
                  sched_context[i] = sched_context[i + 1];
               end
               tasks_held--;
               run_slot = after_remove(run_slot, s);
               chosen_task = after_remove(chosen_task, s);
            end else begin
               r.status = STATUS_ABSENT;
            end
            r.pend_switch = sched_pass();
         end
         REQ_BLOCK: begin
            if (live_slot(run_slot) != IDLE_SLOT) begin
               sched_state[run_slot] = ST_BLOCKED;
               sched_wake[run_slot] = w.wake_tick;
            end
            r.pend_switch = sched_pass();
         end
         REQ_UNBLOCK: begin
            if (live_slot(s) != IDLE_SLOT) sched_state[s] = ST_READY;
            else r.status = STATUS_ABSENT;
         end
         REQ_SWITCH: begin
            if (booting) begin
               c = (tasks_held > 0) ? 0 : IDLE_SLOT;
               run_slot = c;
               chosen_task = c;
               if (c < IDLE_SLOT) sched_state[c] = ST_RUNNING;
               booting = 1'b0;
               r.next_stack_pointer = sched_context[c];
            end else begin
               c = live_slot(run_slot);
               n = live_slot(chosen_task);
               sched_context[c] = w.context_ptr;
               if (n != c) begin
                  if (c < IDLE_SLOT && sched_state[c] == ST_RUNNING) sched_state[c] = ST_READY;
                  run_slot = n;
                  if (n < IDLE_SLOT) sched_state[n] = ST_RUNNING;
                  r.next_stack_pointer = sched_context[n];
               end else begin
                  run_slot = c;
                  r.next_stack_pointer = w.context_ptr;
               end
            end
         end
         default: ;
      endcase
      r.running_task = run_slot[3:0];
      r.selected_task = chosen_task[3:0];
      r.task_count = tasks_held[3:0];
      r.tick_count = ticks;
      return r;
   endfunction

   function automatic stim_row_type row(req_code_type code, logic [7:0] prio,
                                        logic [2:0] s, logic [31:0] wake,
                                        logic [31:0] sp, bit typed = 1'b0,
                                        rsp_word_type want = '0);
      stim_row_type t;
      t.word = '{req_type: code, priority_req: prio, slot: s, wake_tick: wake,
                 context_ptr: sp};
      t.typed = typed;
      t.want = want;
      return t;
   endfunction

   // Random request, weighted so that the table stays partly filled.
   function automatic req_word_type random_request();
      req_word_type w;
      int           pick;
      w.priority_req = 8'($urandom_range(255, 0));
      w.context_ptr = $urandom();
      w.slot = (tasks_held > 0 && $urandom_range(99, 0) < 80) ?
               3'($urandom_range(tasks_held - 1, 0)) : 3'($urandom_range(7, 0));
      pick = $urandom_range(99, 0);
      if (pick < 25) w.wake_tick = 32'd0;
      else if (pick < 70) w.wake_tick = ticks + $urandom_range(6, 0);
      else if (pick < 90) w.wake_tick = $urandom();
      else w.wake_tick = 32'hFFFF_FFFF;
      pick = $urandom_range(99, 0);
      if (tasks_held < 3 && pick < 40) w.req_type = REQ_CREATE;
      else if (pick < 20) w.req_type = REQ_TICK;
      else if (pick < 30) w.req_type = REQ_YIELD;
      else if (pick < 42) w.req_type = REQ_CREATE;
      else if (pick < 51) w.req_type = REQ_REMOVE;
      else if (pick < 64) w.req_type = REQ_BLOCK;
      else if (pick < 77) w.req_type = REQ_UNBLOCK;
      else if (pick < 97) w.req_type = REQ_SWITCH;
      else w.req_type = REQ_NONE;
      return w;
   endfunction

   // Offers one word and waits until it is taken; valid stays high after.
   task automatic send_word(req_word_type w);
      int gap_pct;
      gap_pct = (mode == MODE_SEND_IDLE) ? 87 : (mode == MODE_BOTH) ? 27 : 0;
      while ($urandom_range(99, 0) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the idle stack pointer while the unit is idle.
   task automatic write_idle_sp(logic [31:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sched_context[IDLE_SLOT] = v;
   endtask

   // Response side: stalls by mode or hold-off, checks each taken word.
   always @(posedge clock) begin
      rsp_word_type want;
      int           stall_pct;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (rsp_word.pend_switch) switches_seen++;
            if (pending_rsps.size() == 0) begin
               $error("response word with nothing expected");
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_word.pend_switch !== want.pend_switch) begin
                  $error("pend_switch: expected %0h, got %0h", want.pend_switch,
                         rsp_word.pend_switch);
                  error_count++;
               end
               if (rsp_word.next_stack_pointer !== want.next_stack_pointer) begin
                  $error("next_stack_pointer: expected %0h, got %0h",
                         want.next_stack_pointer, rsp_word.next_stack_pointer);
                  error_count++;
               end
               if (rsp_word.running_task !== want.running_task) begin
                  $error("running_task: expected %0d, got %0d", want.running_task,
                         rsp_word.running_task);
                  error_count++;
               end
               if (rsp_word.selected_task !== want.selected_task) begin
                  $error("selected_task: expected %0d, got %0d", want.selected_task,
                         rsp_word.selected_task);
                  error_count++;
               end
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  error_count++;
               end
               if (rsp_word.task_count !== want.task_count) begin
                  $error("task_count: expected %0d, got %0d", want.task_count,
                         rsp_word.task_count);
                  error_count++;
               end
               if (rsp_word.tick_count !== want.tick_count) begin
                  $error("tick_count: expected %0h, got %0h", want.tick_count,
                         rsp_word.tick_count);
                  error_count++;
               end
            end
         end
         stall_pct = (mode == MODE_RECV_STALL) ? 87 : (mode == MODE_BOTH) ? 27 : 0;
         rsp_stall <= (cycle_count < hold_until) || ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_priority_task_scheduler_unit: errors");
            $finish;
         end
      end
   end

   // Stimulus: reset, directed table, then random phases.
   initial begin
      rsp_word_type want;
      logic [31:0]  idle_values [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      error_count = 0;
      mode = MODE_FREE;
      cycle_count = 0;
      hold_until = 0;
      quiet_cycles = 0;
      words_sent = 0;
      words_checked = 0;
      switches_seen = 0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         sched_state[i] = ST_READY;
         sched_wake[i] = 32'd0;
      end
      tasks_held = 0;
      run_slot = 0;
      chosen_task = 0;
      booting = 1'b1;
      ticks = 32'd0;

      // Typed rows: empty table after reset, the full table and absent slots.
      directed_rows[0] = row(REQ_TICK, 8'd0, 3'd0, 32'd0, 32'd0, 1'b1,
                             '{1'b1, 32'd0, 4'd8, 4'd8, STATUS_OK, 4'd0, 32'd1});
      directed_rows[1] = row(REQ_REMOVE, 8'd0, 3'd3, 32'd0, 32'd0, 1'b1,
                             '{1'b0, 32'd0, 4'd8, 4'd8, STATUS_ABSENT, 4'd0, 32'd1});
      directed_rows[2] = row(REQ_UNBLOCK, 8'd0, 3'd7, 32'd0, 32'd0, 1'b1,
                             '{1'b0, 32'd0, 4'd8, 4'd8, STATUS_ABSENT, 4'd0, 32'd1});
      directed_rows[3] = row(REQ_NONE, 8'hFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      directed_rows[4] = row(REQ_CREATE, 8'd10, 3'd7, 32'hFFFF_FFFF, 32'h0000_0000);
      directed_rows[5] = row(REQ_CREATE, 8'd255, 3'd0, 32'd0, 32'hFFFF_FFFF);
      directed_rows[6] = row(REQ_CREATE, 8'd0, 3'd5, 32'd9, 32'h0000_1234);
      directed_rows[7] = row(REQ_CREATE, 8'd3, 3'd2, 32'd0, 32'hA5A5_5A5A);
      directed_rows[8] = row(REQ_CREATE, 8'd3, 3'd1, 32'd0, 32'h5A5A_A5A5);
      directed_rows[9] = row(REQ_CREATE, 8'd200, 3'd0, 32'd0, 32'h8000_0000);
      directed_rows[10] = row(REQ_CREATE, 8'd0, 3'd0, 32'd0, 32'h0000_0001);
      directed_rows[11] = row(REQ_CREATE, 8'd7, 3'd6, 32'd0, 32'h7FFF_FFFF);
      directed_rows[12] = row(REQ_CREATE, 8'd1, 3'd0, 32'd0, 32'hDEAD_0000, 1'b1,
                              '{1'b0, 32'd0, 4'd8, 4'd8, STATUS_FULL, 4'd8, 32'd1});
      directed_rows[13] = row(REQ_SWITCH, 8'd0, 3'd0, 32'd0, 32'h1111_0000);
      directed_rows[14] = row(REQ_TICK, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[15] = row(REQ_BLOCK, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[16] = row(REQ_SWITCH, 8'd0, 3'd0, 32'd0, 32'h2222_0000);
      directed_rows[17] = row(REQ_BLOCK, 8'd0, 3'd0, 32'hFFFF_FFFF, 32'd0);
      directed_rows[18] = row(REQ_YIELD, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[19] = row(REQ_SWITCH, 8'd0, 3'd0, 32'd0, 32'h3333_0000);
      directed_rows[20] = row(REQ_UNBLOCK, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[21] = row(REQ_REMOVE, 8'd0, 3'd7, 32'd0, 32'd0);
      directed_rows[22] = row(REQ_REMOVE, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[23] = row(REQ_TICK, 8'd0, 3'd0, 32'd0, 32'd0);
      directed_rows[24] = row(REQ_SWITCH, 8'd0, 3'd0, 32'd0, 32'h4444_0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_idle_sp(32'hFFFF_FFFF);

      // Directed part: typed rows still advance the predicted state.
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word);
         want = schedule_request(directed_rows[i].word);
         pending_rsps.push_back(directed_rows[i].typed ? directed_rows[i].want : want);
      end
      wait_drained();

      // Random phases, each under its own idle mode and idle stack pointer.
      idle_values[0] = 32'd0;
      idle_values[1] = $urandom();
      idle_values[2] = 32'hFFFF_FFFF;
      idle_values[3] = $urandom();
      for (int p = MODE_FREE; p <= MODE_BOTH; p++) begin
         write_idle_sp(idle_values[p]);
         mode <= p;
         for (int n = 0; n < 360; n++) begin
            req_word_type w;
            w = random_request();
            // Long response hold-off while requests keep coming.
            if (p == MODE_FREE && n == 60) hold_until <= cycle_count + HOLD_CYCLES;
            // Sender pause until every response is back.
            if (p == MODE_FREE && n == 200) begin
               req_valid <= 1'b0;
               while (pending_rsps.size() != 0) @(posedge clock);
            end
            send_word(w);
            pending_rsps.push_back(schedule_request(w));
         end
         wait_drained();
      end

      $display("Sent %0d request words and checked %0d responses (%0d with a switch pending),",
               words_sent, words_checked, switches_seen);
      $display("over four idle and stall modes and five idle stack pointer settings.");
      if (error_count == 0) begin
         $display("tb_priority_task_scheduler_unit: clean");
      end else begin
         $display("tb_priority_task_scheduler_unit: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pts_pkg.sv
rtl/core/pts_ctrl.sv
rtl/core/pts_dpath.sv
rtl/core/priority_task_scheduler_unit.sv
tb/tb_priority_task_scheduler_unit.sv
